@@ sv/tmre_pkg.sv @@
// Shared types, codes and helper functions for the trackball motion report engine.
// No dependencies; every other file imports this package.
package tmre_pkg;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_ACCEL_ENABLE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPEED_SELECT = 1'b1;

    localparam logic [2:0] SCROLL_MODE_RESET = 3'h4;
    localparam logic [2:0] ENABLE_H          = 3'h6;
    localparam logic [2:0] ENABLE_V          = 3'h5;
    localparam logic [1:0] SPEED_RESET       = 2'd3;

    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = 19;
    localparam int NUM_W       = 16;
    localparam int PROD_W      = 34;
    localparam int QUO_W       = 14;

    typedef struct packed {
        logic       action;
        logic [2:0] buttons_raw;
        logic       toggle_pin;
        logic       x_phase_a;
        logic       x_phase_b;
        logic       y_phase_a;
        logic       y_phase_b;
        logic       host_ready;
    } tmre_in_t;

    typedef struct packed {
        logic [2:0]        button_bits;
        logic signed [7:0] delta_x;
        logic signed [7:0] delta_y;
        logic signed [7:0] wheel_vertical;
        logic signed [7:0] wheel_horizontal;
    } tmre_out_t;

    typedef enum logic [1:0] {
        KIND_TICK,
        KIND_PRIME,
        KIND_POLL
    } tmre_kind_t;

    typedef struct packed {
        tmre_kind_t kind;
        logic [2:0] buttons_raw;
        logic       toggled;
        logic [3:0] phases;
        logic       host_ready;
    } tmre_item_t;

    typedef enum logic [2:0] {
        ST_EXEC,
        ST_SQUARE,
        ST_RECIP,
        ST_FIX,
        ST_EMIT
    } tmre_state_t;

    function automatic logic [1:0] linearity(input logic [1:0] speed);
        logic [1:0] l;
        unique case (speed)
            2'd0:    l = 2'd1;
            2'd1:    l = 2'd1;
            2'd2:    l = 2'd2;
            default: l = 2'd3;
        endcase
        return l;
    endfunction

    function automatic logic [2:0] accel_divisor(input logic [1:0] speed);
        return {linearity(speed), 1'b1};
    endfunction

    // floor(2^20 / divisor)
    function automatic logic [RECIP_W-1:0] accel_recip(input logic [1:0] speed);
        logic [RECIP_W-1:0] r;
        unique case (speed)
            2'd0:    r = RECIP_W'(349525);
            2'd1:    r = RECIP_W'(349525);
            2'd2:    r = RECIP_W'(209715);
            default: r = RECIP_W'(149796);
        endcase
        return r;
    endfunction

    function automatic logic [7:0] scroll_divider(input logic [1:0] speed);
        return 8'd8 << speed;
    endfunction

    // one unit step, saturated at -127 and +127
    function automatic logic [7:0] sat_step(input logic [7:0] acc, input logic neg);
        logic [7:0] r;
        if (neg)
        begin
            r = (acc == 8'h81) ? acc : acc - 8'd1;
        end
        else
        begin
            r = (acc == 8'h7f) ? acc : acc + 8'd1;
        end
        return r;
    endfunction

endpackage

@@ sv/tmre_front.sv @@
// Front end: accepts input transactions, classifies them and pushes them to the queue.
// Depends on tmre_pkg.
module tmre_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tmre_pkg::tmre_in_t  in_data,
    input  logic                q_full,
    output logic                q_push,
    output tmre_pkg::tmre_item_t q_item
);
    import tmre_pkg::*;

    logic primed_reg;
    logic primed_next;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        primed_next       = primed_reg;
        q_item.buttons_raw = in_data.buttons_raw;
        q_item.toggled     = in_data.toggle_pin;
        q_item.phases      = {in_data.y_phase_b, in_data.y_phase_a,
                              in_data.x_phase_b, in_data.x_phase_a};
        q_item.host_ready  = in_data.host_ready;
        if (!in_data.action)
        begin
            q_item.kind = KIND_TICK;
        end
        else if (!primed_reg)
        begin
            q_item.kind = KIND_PRIME;
            if (q_push)
            begin
                primed_next = 1'b1;
            end
        end
        else
        begin
            q_item.kind = KIND_POLL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg <= 1'b0;
        end
        else
        begin
            primed_reg <= primed_next;
        end
    end

endmodule

@@ sv/tmre_queue.sv @@
// Short queue of classified items between front and back end.
// Depends on tmre_pkg.
module tmre_queue #(
    parameter int DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  tmre_pkg::tmre_item_t push_item,
    output logic                 full,
    input  logic                 pop,
    output logic                 empty,
    output tmre_pkg::tmre_item_t head
);
    import tmre_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    tmre_item_t       mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ sv/tmre_back.sv @@
// Back end: debouncer, quadrature and scroll decode, report build, acceleration
// and the output register. Depends on tmre_pkg.
module tmre_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [tmre_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tmre_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              q_empty,
    input  tmre_pkg::tmre_item_t              q_head,
    output logic                              q_pop,
    output logic                              out_valid,
    input  logic                              out_ready,
    output tmre_pkg::tmre_out_t               out_data
);
    import tmre_pkg::*;

    typedef struct packed {
        logic [7:0] acc;
        logic [7:0] wheel;
        logic [7:0] count;
        logic       changed;
    } axis_res_t;

    function automatic axis_res_t axis_step(
        input logic       a,
        input logic       b,
        input logic       pa,
        input logic       pb,
        input logic       tog,
        input logic       flip,
        input logic       en,
        input logic [7:0] acc,
        input logic [7:0] wheel,
        input logic [7:0] count,
        input logic [7:0] div
    );
        axis_res_t r;
        logic      neg;
        r.acc     = acc;
        r.wheel   = wheel;
        r.count   = count;
        r.changed = 1'b0;
        neg = (a ^ b) ^ ~(a ^ pa);
        if ((a ^ pa) | (b ^ pb))
        begin
            if (!tog)
            begin
                r.acc     = sat_step(acc, neg ^ flip);
                r.changed = 1'b1;
            end
            else if (en && (count == div || count == 8'd0 - div))
            begin
                r.wheel   = sat_step(wheel, neg);
                r.count   = '0;
                r.changed = 1'b1;
            end
            else
            begin
                r.count = neg ? count - 8'd1 : count + 8'd1;
            end
        end
        return r;
    endfunction

    tmre_state_t state_reg, state_next;

    logic       accel_enable_reg;
    logic [1:0] speed_select_reg;

    logic [2:0] stable_reg, stable_next;
    logic [2:0] vlow_reg, vlow_next;
    logic [2:0] vhigh_reg, vhigh_next;
    logic [2:0] latch_reg, latch_next;
    logic [2:0] prev_press_reg, prev_press_next;
    logic [2:0] mode_reg, mode_next;
    logic [7:0] count_h_reg, count_h_next;
    logic [7:0] count_v_reg, count_v_next;
    logic [3:0] phases_reg, phases_next;
    logic [2:0] rbuttons_reg, rbuttons_next;
    logic [7:0] acc_x_reg, acc_x_next;
    logic [7:0] acc_y_reg, acc_y_next;
    logic [7:0] acc_wv_reg, acc_wv_next;
    logic [7:0] acc_wh_reg, acc_wh_next;
    logic       pending_reg, pending_next;
    logic       report_now;

    tmre_out_t  rep_reg, rep_next;
    tmre_out_t  out_reg;
    logic       out_valid_reg;
    logic       out_load;

    logic [NUM_W-1:0]  lane_n_reg [2];
    logic [PROD_W-1:0] lane_p_reg [2];
    logic [7:0]        lane_val [2];
    logic [7:0]        lane_fix [2];

    // control
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_EXEC:
            begin
                if (!q_empty && report_now)
                begin
                    state_next = accel_enable_reg ? ST_SQUARE : ST_EMIT;
                end
            end
            ST_SQUARE: state_next = ST_RECIP;
            ST_RECIP:  state_next = ST_FIX;
            ST_FIX:    state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_EXEC;
                end
            end
            default:   state_next = ST_EXEC;
        endcase
    end

    always_comb
    begin
        q_pop    = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_EXEC: q_pop    = !q_empty;
            ST_EMIT: out_load = !out_valid_reg || out_ready;
            default:
            begin
                q_pop    = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    // item execution
    always_comb
    begin
        logic [2:0] pressed;
        logic [2:0] diff;
        logic [2:0] now;
        logic [7:0] div;
        axis_res_t  rx;
        axis_res_t  ry;

        stable_next     = stable_reg;
        vlow_next       = vlow_reg;
        vhigh_next      = vhigh_reg;
        latch_next      = latch_reg;
        prev_press_next = prev_press_reg;
        mode_next       = mode_reg;
        count_h_next    = count_h_reg;
        count_v_next    = count_v_reg;
        phases_next     = phases_reg;
        rbuttons_next   = rbuttons_reg;
        acc_x_next      = acc_x_reg;
        acc_y_next      = acc_y_reg;
        acc_wv_next     = acc_wv_reg;
        acc_wh_next     = acc_wh_reg;
        pending_next    = pending_reg;
        report_now      = 1'b0;
        rep_next        = rep_reg;

        pressed = ~q_head.buttons_raw;
        diff    = stable_reg ^ pressed;
        now     = latch_reg;
        div     = scroll_divider(speed_select_reg);
        rx      = '0;
        ry      = '0;

        unique case (q_head.kind)
            KIND_TICK:
            begin
                vlow_next   = ~(vlow_reg & diff);
                vhigh_next  = (vlow_next ^ vhigh_reg) & diff;
                diff        = diff & vlow_next & vhigh_next;
                stable_next = stable_reg ^ diff;
                latch_next  = latch_reg | (stable_next & diff);
            end
            KIND_PRIME:
            begin
                phases_next = q_head.phases;
            end
            default:
            begin
                if (prev_press_reg != now)
                begin
                    latch_next = '0;
                    if (q_head.toggled)
                    begin
                        if (now != '0)
                        begin
                            mode_next    = now;
                            count_h_next = div;
                            count_v_next = div;
                        end
                    end
                    else
                    begin
                        rbuttons_next = now;
                        pending_next  = 1'b1;
                    end
                end

                rx = axis_step(q_head.phases[0], q_head.phases[1],
                               phases_reg[0], phases_reg[1], q_head.toggled, 1'b0,
                               (mode_next & ENABLE_H) != '0,
                               acc_x_reg, acc_wh_reg, count_h_next, div);
                ry = axis_step(q_head.phases[2], q_head.phases[3],
                               phases_reg[2], phases_reg[3], q_head.toggled, 1'b1,
                               (mode_next & ENABLE_V) != '0,
                               acc_y_reg, acc_wv_reg, count_v_next, div);
                acc_x_next   = rx.acc;
                acc_wh_next  = rx.wheel;
                count_h_next = rx.count;
                acc_y_next   = ry.acc;
                acc_wv_next  = ry.wheel;
                count_v_next = ry.count;
                if (rx.changed || ry.changed)
                begin
                    pending_next = 1'b1;
                end

                prev_press_next = now;
                phases_next     = q_head.phases;

                if (pending_next && q_head.host_ready)
                begin
                    report_now                = 1'b1;
                    rep_next.button_bits      = rbuttons_next;
                    rep_next.delta_x          = acc_x_next;
                    rep_next.delta_y          = acc_y_next;
                    rep_next.wheel_vertical   = acc_wv_next;
                    rep_next.wheel_horizontal = acc_wh_next;
                    acc_x_next   = '0;
                    acc_y_next   = '0;
                    acc_wv_next  = '0;
                    acc_wh_next  = '0;
                    pending_next = 1'b0;
                end
            end
        endcase

        if (!q_pop)
        begin
            stable_next     = stable_reg;
            vlow_next       = vlow_reg;
            vhigh_next      = vhigh_reg;
            latch_next      = latch_reg;
            prev_press_next = prev_press_reg;
            mode_next       = mode_reg;
            count_h_next    = count_h_reg;
            count_v_next    = count_v_reg;
            phases_next     = phases_reg;
            rbuttons_next   = rbuttons_reg;
            acc_x_next      = acc_x_reg;
            acc_y_next      = acc_y_reg;
            acc_wv_next     = acc_wv_reg;
            acc_wh_next     = acc_wh_reg;
            pending_next    = pending_reg;
            rep_next        = rep_reg;
        end

        if (state_reg == ST_FIX)
        begin
            rep_next.delta_x = lane_fix[0];
            rep_next.delta_y = lane_fix[1];
        end
    end

    // acceleration lanes: square, reciprocal multiply, correct and saturate
    assign lane_val[0] = rep_reg.delta_x;
    assign lane_val[1] = rep_reg.delta_y;

    always_comb
    begin
        logic [QUO_W-1:0]   q0;
        logic [QUO_W+2:0]   q0d;
        logic [QUO_W+2:0]   rem;
        logic [QUO_W-1:0]   q;
        logic [6:0]         q7;
        logic [2:0]         d;
        d = accel_divisor(speed_select_reg);
        for (int i = 0; i < 2; i++)
        begin
            q0  = lane_p_reg[i][RECIP_SHIFT +: QUO_W];
            q0d = (QUO_W+3)'(q0) * (QUO_W+3)'(d);
            rem = {1'b0, lane_n_reg[i]} - q0d;
            q   = q0 + QUO_W'(rem >= {{QUO_W{1'b0}}, d});
            q7  = (q > QUO_W'(127)) ? 7'd127 : q[6:0];
            lane_fix[i] = lane_val[i][7] ? 8'd0 - {1'b0, q7} : {1'b0, q7};
        end
    end

    always_ff @(posedge clk)
    begin
        logic [6:0]       m;
        logic [7:0]       ml;
        logic [NUM_W-2:0] sq;
        for (int i = 0; i < 2; i++)
        begin
            m  = lane_val[i][7] ? 7'(8'd0 - lane_val[i]) : lane_val[i][6:0];
            ml = {1'b0, m} + {6'd0, linearity(speed_select_reg)};
            sq = (NUM_W-1)'(m) * (NUM_W-1)'(ml);
            if (state_reg == ST_SQUARE)
            begin
                lane_n_reg[i] <= {sq, 1'b0};
            end
            if (state_reg == ST_RECIP)
            begin
                lane_p_reg[i] <= PROD_W'(lane_n_reg[i])
                                 * PROD_W'(accel_recip(speed_select_reg));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rep_reg <= rep_next;
        if (out_load)
        begin
            out_reg <= rep_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_EXEC;
            accel_enable_reg <= 1'b0;
            speed_select_reg <= SPEED_RESET;
            stable_reg       <= '0;
            vlow_reg         <= '0;
            vhigh_reg        <= '0;
            latch_reg        <= '0;
            prev_press_reg   <= '0;
            mode_reg         <= SCROLL_MODE_RESET;
            count_h_reg      <= '0;
            count_v_reg      <= '0;
            phases_reg       <= '0;
            rbuttons_reg     <= '0;
            acc_x_reg        <= '0;
            acc_y_reg        <= '0;
            acc_wv_reg       <= '0;
            acc_wh_reg       <= '0;
            pending_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            stable_reg     <= stable_next;
            vlow_reg       <= vlow_next;
            vhigh_reg      <= vhigh_next;
            latch_reg      <= latch_next;
            prev_press_reg <= prev_press_next;
            mode_reg       <= mode_next;
            count_h_reg    <= count_h_next;
            count_v_reg    <= count_v_next;
            phases_reg     <= phases_next;
            rbuttons_reg   <= rbuttons_next;
            acc_x_reg      <= acc_x_next;
            acc_y_reg      <= acc_y_next;
            acc_wv_reg     <= acc_wv_next;
            acc_wh_reg     <= acc_wh_next;
            pending_reg    <= pending_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_ACCEL_ENABLE: accel_enable_reg <= cfg_data[0];
                    default:          speed_select_reg <= cfg_data;
                endcase
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

@@ sv/trackball_motion_report_engine_core.sv @@
// Trackball motion report engine: debounced buttons, quadrature motion and scroll reports.
// A reporting poll passes the queue, the execute state and the emit state into the output
// register; with acceleration also the square, reciprocal multiply and correction states.
// Throughput: one transaction a cycle while no report is being built or held by out_ready.
// Reset clears all control and motion state; scroll mode resets to both axes, speed to 3.
// Depends on tmre_pkg, tmre_front, tmre_queue and tmre_back.
module trackball_motion_report_engine_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [tmre_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tmre_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  tmre_pkg::tmre_in_t                in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output tmre_pkg::tmre_out_t               out_data
);
    import tmre_pkg::*;

    tmre_item_t push_item;
    tmre_item_t head_item;
    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_empty;

    tmre_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    tmre_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (head_item)
    );

    tmre_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_empty   (q_empty),
        .q_head    (head_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
